// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset.
`define FFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define FFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define FFA_ASSERT(lbl, prop, msg)
`define FFA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/ffa_pkg.sv =====
// Package for the first-fit free-list allocator: beat types, codes and
// sequencer states. No dependencies.
package ffa_pkg;

  // Default depth of the free-segment list.
  localparam int unsigned MAX_SEGMENTS_DEF = 16;

  // Register file address width (two 32-bit registers at 0x0 and 0x4).
  localparam int unsigned PADDR_W = 3;

  // Register select, taken from paddr bit 2.
  localparam logic REG_POOL_BASE  = 1'b0;
  localparam logic REG_POOL_BYTES = 1'b1;

  // Request operations.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        func;
    logic [31:0] req_bytes;
    logic [31:0] release_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] grant_addr;
    logic [31:0] free_total;
  } out_item_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // Request to the shared add/subtract unit.
  typedef struct packed {
    alu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  // Answer of the shared unit; carry is the borrow on a subtract.
  typedef struct packed {
    logic [31:0] res;
    logic        carry;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CARVE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PUSH,
    S_TALLY,
    S_DONE
  } state_e;

endpackage

// ===== rtl/core/ffa_addsub.sv =====
// Shared 32-bit add/subtract unit of the allocator sequencer.
// Depends on ffa_pkg for the request and answer types.
module ffa_addsub
  import ffa_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [32:0] sum;

  // One 33-bit adder; the top bit is the carry out or the borrow.
  always_comb begin
    if (req_i.op == ALU_SUB) begin
      sum = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      sum = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
    rsp_o.res   = sum[31:0];
    rsp_o.carry = sum[32];
  end

endmodule

// ===== rtl/core/first_fit_free_list_allocator_core.sv =====
// Top level of the first-fit free-list allocator: sequencer, segment memory
// and register file. Depends on ffa_pkg, ffa_addsub and assert_macros.svh.
//
//   Channel  | Direction | Handshake             | Payload
//   ---------+-----------+-----------------------+---------------------------------
//   in       | in        | in_valid_i/in_stall_o | in_item_i  (func, req, addr)
//   out      | out       | out_valid_o/out_stall_i | out_item_o (status, grant, total)
//   config   | in        | psel/penable/pready   | paddr, pwdata, prdata
//
// One request is worked at a time. An allocate reads the list from the head
// until a segment fits, carves the request from its front and moves the tail
// up if that segment is used up; a miss ends at the last entry. A free shifts
// every entry down, one memory read and write each, and pushes the freed
// segment at the head. Reset empties the list at once: no clearing pass. A
// stalled result sits in the output register while the next request is taken
// and worked.
`include "assert_macros.svh"

module first_fit_free_list_allocator_core
  import ffa_pkg::*;
#(
  parameter int unsigned MaxSegments = MAX_SEGMENTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  // Register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned IdxW = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int unsigned CntW = $clog2(MaxSegments + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxSegments);

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
  } seg_t;

  // Sequencer and datapath registers.
  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] seg_count_q, seg_count_d;
  logic [31:0]     free_bytes_q, free_bytes_d;
  logic [31:0]     pool_base_q, pool_base_d;
  logic [31:0]     pool_bytes_q, pool_bytes_d;
  in_item_t        item_q, item_d;
  logic [1:0]      status_q, status_d;
  logic [31:0]     grant_q, grant_d;
  logic [31:0]     hit_base_q, hit_base_d;
  logic [31:0]     rem_q, rem_d;
  logic            out_valid_q;
  out_item_t       out_item_q;

  // Segment memory, one write and one registered read port.
  seg_t            seg_mem [MaxSegments];
  seg_t            rd_data_q;
  logic [IdxW-1:0] rd_addr;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  seg_t            mem_wdata;

  alu_req_t        alu_req;
  alu_rsp_t        alu_rsp;

  logic            accept_in;
  logic            cfg_wr;
  logic            out_load;
  logic            fit;
  logic            drop;
  logic [CntW-1:0] idx_p1;
  logic [CntW-1:0] idx_p2;

  ffa_addsub u_addsub (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Handshakes.
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept_in   = in_valid_i && !in_stall_o;
  assign cfg_wr      = psel && penable && pwrite;
  assign out_load    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Register read-back.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POOL_BYTES) ? pool_bytes_q : pool_base_q;

  // Index arithmetic and scan decisions.
  assign idx_p1 = CntW'(idx_q) + CntW'(1);
  assign idx_p2 = CntW'(idx_q) + CntW'(2);
  assign fit    = !alu_rsp.carry;
  assign drop   = (rem_q == 32'd0) && (item_q.req_bytes != 32'd0);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept_in) begin
          if (in_item_i.func == FUNC_ALLOC) begin
            state_d = (seg_count_q == '0) ? S_DONE : S_SCAN;
          end else if (in_item_i.req_bytes == 32'd0 || seg_count_q == CntMax) begin
            state_d = S_DONE;
          end else if (seg_count_q == '0) begin
            state_d = S_PUSH;
          end else begin
            state_d = S_SHIFT_DN;
          end
        end
      end
      S_SCAN: begin
        if (fit) begin
          state_d = S_CARVE;
        end else if (idx_p1 == seg_count_q) begin
          state_d = S_DONE;
        end
      end
      S_CARVE: begin
        state_d = (drop && idx_p1 != seg_count_q) ? S_SHIFT_UP : S_TALLY;
      end
      S_SHIFT_UP: begin
        if (idx_p1 == seg_count_q) begin
          state_d = S_TALLY;
        end
      end
      S_SHIFT_DN: begin
        if (idx_q == '0) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH:  state_d = S_TALLY;
      S_TALLY: state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory ports and shared unit control.
  always_comb begin
    idx_d        = idx_q;
    seg_count_d  = seg_count_q;
    free_bytes_d = free_bytes_q;
    pool_base_d  = pool_base_q;
    pool_bytes_d = pool_bytes_q;
    item_d       = item_q;
    status_d     = status_q;
    grant_d      = grant_q;
    hit_base_d   = hit_base_q;
    rem_d        = rem_q;
    rd_addr      = idx_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = rd_data_q;
    alu_req.op   = ALU_ADD;
    alu_req.a    = free_bytes_q;
    alu_req.b    = item_q.req_bytes;

    case (state_q)
      S_IDLE: begin
        // A register write rebuilds the list as one pool segment, or empty for a zero-byte pool.
        if (cfg_wr) begin
          if (paddr[2] == REG_POOL_BYTES) begin
            pool_bytes_d = pwdata;
          end else begin
            pool_base_d = pwdata;
          end
          free_bytes_d   = pool_bytes_d;
          seg_count_d    = (pool_bytes_d != 32'd0) ? CntW'(1) : '0;
          mem_we         = 1'b1;
          mem_waddr      = '0;
          mem_wdata.base = pool_base_d;
          mem_wdata.size = pool_bytes_d;
        end
        if (accept_in) begin
          item_d   = in_item_i;
          grant_d  = 32'd0;
          status_d = ST_DONE;
          if (in_item_i.func == FUNC_ALLOC) begin
            idx_d   = '0;
            rd_addr = '0;
            if (seg_count_q == '0) begin
              status_d = ST_NOFIT;
            end
          end else begin
            // The shift down starts at the tail entry.
            idx_d   = IdxW'(seg_count_q - CntW'(1));
            rd_addr = IdxW'(seg_count_q - CntW'(1));
            if (in_item_i.req_bytes != 32'd0 && seg_count_q == CntMax) begin
              status_d = ST_FULL;
            end
          end
        end
      end
      S_SCAN: begin
        // Compare by subtraction; the difference is the remainder on a hit.
        alu_req.op = ALU_SUB;
        alu_req.a  = rd_data_q.size;
        alu_req.b  = item_q.req_bytes;
        if (fit) begin
          hit_base_d = rd_data_q.base;
          rem_d      = alu_rsp.res;
        end else if (idx_p1 == seg_count_q) begin
          status_d = ST_NOFIT;
        end else begin
          idx_d   = IdxW'(idx_p1);
          rd_addr = IdxW'(idx_p1);
        end
      end
      S_CARVE: begin
        // Carve the request from the front of the hit segment.
        alu_req.op     = ALU_ADD;
        alu_req.a      = hit_base_q;
        alu_req.b      = item_q.req_bytes;
        mem_we         = 1'b1;
        mem_waddr      = idx_q;
        mem_wdata.base = alu_rsp.res;
        mem_wdata.size = rem_q;
        grant_d        = hit_base_q;
        rd_addr        = IdxW'(idx_p1);
        if (drop) begin
          seg_count_d = seg_count_q - CntW'(1);
        end
      end
      S_SHIFT_UP: begin
        // Entry idx+1 moves to idx; the count is already one less.
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rd_data_q;
        if (idx_p1 != seg_count_q) begin
          idx_d   = IdxW'(idx_p1);
          rd_addr = IdxW'(idx_p2);
        end
      end
      S_SHIFT_DN: begin
        // Entry idx moves to idx+1, walking towards the head.
        mem_we    = 1'b1;
        mem_waddr = IdxW'(idx_p1);
        mem_wdata = rd_data_q;
        if (idx_q != '0) begin
          idx_d   = idx_q - IdxW'(1);
          rd_addr = idx_q - IdxW'(1);
        end
      end
      S_PUSH: begin
        mem_we         = 1'b1;
        mem_waddr      = '0;
        mem_wdata.base = item_q.release_addr;
        mem_wdata.size = item_q.req_bytes;
        seg_count_d    = seg_count_q + CntW'(1);
      end
      S_TALLY: begin
        // Free total moves by the request size, wrapping modulo 2^32.
        alu_req.op   = (item_q.func == FUNC_FREE) ? ALU_ADD : ALU_SUB;
        alu_req.a    = free_bytes_q;
        alu_req.b    = item_q.req_bytes;
        free_bytes_d = alu_rsp.res;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      seg_count_q  <= '0;
      free_bytes_q <= 32'd0;
      pool_base_q  <= 32'd0;
      pool_bytes_q <= 32'd0;
      status_q     <= ST_DONE;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      seg_count_q  <= seg_count_d;
      free_bytes_q <= free_bytes_d;
      pool_base_q  <= pool_base_d;
      pool_bytes_q <= pool_bytes_d;
      status_q     <= status_d;
      if (state_q == S_DONE && out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    grant_q    <= grant_d;
    hit_base_q <= hit_base_d;
    rem_q      <= rem_d;
    if (state_q == S_DONE && out_load) begin
      out_item_q.status     <= status_q;
      out_item_q.grant_addr <= grant_q;
      out_item_q.free_total <= free_bytes_q;
    end
  end

  // Segment memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= seg_mem[rd_addr];
  end

  // Checks on the sequencer.
  `FFA_ASSERT_ALWAYS(a_count_bound, !rst_ni || seg_count_q <= CntMax, "segment count above list depth")
  `FFA_ASSERT(a_scan_in_list, state_q == S_SCAN |-> CntW'(idx_q) < seg_count_q, "scan past list end")
  `FFA_ASSERT(a_push_grows, state_q == S_PUSH |=> seg_count_q == $past(seg_count_q) + CntW'(1), "push did not grow list")
  `FFA_ASSERT(a_full_status, (state_q == S_DONE && status_q == ST_FULL) |-> seg_count_q == CntMax, "full status on list with room")
  `FFA_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result beat raised outside done")

endmodule

// ===== test/allocator_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the first-fit free-list allocator. It follows the request,
// result and register channels, predicts every result and compares it.
// Depends on ffa_pkg.
module allocator_checker
  import ffa_pkg::*;
#(
  parameter int unsigned MaxSegments = MAX_SEGMENTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_item_t           in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_item_t          out_item_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic [31:0]        prdata_i,
  input  logic               pready_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 requests_o,
  output int                 grants_o,
  output int                 nofit_o,
  output int                 full_o
);

  // Shadow copy of the registers and of the free-segment list.
  logic [31:0] pool_base_q;
  logic [31:0] pool_bytes_q;
  logic [31:0] seg_base [MaxSegments];
  logic [31:0] seg_size [MaxSegments];
  int          seg_count;
  logic [31:0] free_bytes_q;

  // Results predicted but not yet seen on the result channel.
  out_item_t   pending_results [$];

  // The list restarts as one segment covering the pool, or empty.
  function automatic void rebuild_list();
    for (int k = 0; k < MaxSegments; k++) begin
      seg_base[k] = '0;
      seg_size[k] = '0;
    end
    seg_count    = 0;
    free_bytes_q = pool_bytes_q;
    if (pool_bytes_q != '0) begin
      seg_base[0] = pool_base_q;
      seg_size[0] = pool_bytes_q;
      seg_count   = 1;
    end
  endfunction

  // Removes a used-up segment and closes the gap behind it.
  function automatic void drop_segment(int idx);
    for (int k = idx; k + 1 < seg_count; k++) begin
      seg_base[k] = seg_base[k+1];
      seg_size[k] = seg_size[k+1];
    end
    seg_count--;
    seg_base[seg_count] = '0;
    seg_size[seg_count] = '0;
  endfunction

  // Works one request against the shadow list and returns its result.
  function automatic out_item_t predict_result(in_item_t req);
    out_item_t res;
    int        hit;
    res.status     = ST_DONE;
    res.grant_addr = '0;
    hit            = -1;
    if (req.func == FUNC_ALLOC) begin
      for (int k = 0; k < seg_count; k++) begin
        if (hit < 0 && seg_size[k] >= req.req_bytes) hit = k;
      end
      if (hit < 0) begin
        res.status = ST_NOFIT;
      end else begin
        res.grant_addr = seg_base[hit];
        seg_base[hit]  = seg_base[hit] + req.req_bytes;
        seg_size[hit]  = seg_size[hit] - req.req_bytes;
        free_bytes_q   = free_bytes_q - req.req_bytes;
        if (seg_size[hit] == '0 && req.req_bytes != '0) drop_segment(hit);
      end
    end else if (req.req_bytes != '0) begin
      if (seg_count >= MaxSegments) begin
        res.status = ST_FULL;
      end else begin
        for (int k = seg_count; k > 0; k--) begin
          seg_base[k] = seg_base[k-1];
          seg_size[k] = seg_size[k-1];
        end
        seg_base[0]  = req.release_addr;
        seg_size[0]  = req.req_bytes;
        seg_count++;
        free_bytes_q = free_bytes_q + req.req_bytes;
      end
    end
    res.free_total = free_bytes_q;
    return res;
  endfunction

  // Compares one accepted result beat with the oldest prediction.
  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $error("result beat with no request outstanding: status %0d grant %h total %h",
             got.status, got.grant_addr, got.free_total);
      fail_count_o++;
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) begin
      $error("status expected %0d got %0d", want.status, got.status);
      fail_count_o++;
    end
    if (got.grant_addr !== want.grant_addr) begin
      $error("grant_addr expected %h got %h", want.grant_addr, got.grant_addr);
      fail_count_o++;
    end
    if (got.free_total !== want.free_total) begin
      $error("free_total expected %h got %h", want.free_total, got.free_total);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  = '0;
      pool_bytes_q = '0;
      rebuild_list();
      pending_results.delete();
      fail_count_o = 0;
      requests_o   = 0;
      grants_o     = 0;
      nofit_o      = 0;
      full_o       = 0;
    end else begin
      // Register port: a write rebuilds the list, a read must match the shadow.
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[2] == REG_POOL_BASE) pool_base_q = pwdata_i;
          else pool_bytes_q = pwdata_i;
          rebuild_list();
        end else if (prdata_i !== ((paddr_i[2] == REG_POOL_BASE) ? pool_base_q
                                                                  : pool_bytes_q)) begin
          $error("prdata expected %h got %h",
                 (paddr_i[2] == REG_POOL_BASE) ? pool_base_q : pool_bytes_q, prdata_i);
          fail_count_o++;
        end
      end
      // Results are matched before this edge's request is added.
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (in_valid_i && !in_stall_i) begin
        out_item_t res;
        res = predict_result(in_item_i);
        pending_results.push_back(res);
        requests_o++;
        if (res.status == ST_NOFIT) nofit_o++;
        else if (res.status == ST_FULL) full_o++;
        else if (in_item_i.func == FUNC_ALLOC) grants_o++;
      end
    end
    pending_o = pending_results.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request and result traffic
// and register writes. Depends on ffa_pkg, allocator_checker and the core.
module testbench;
  import ffa_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;
  int requests;
  int grants;
  int nofit;
  int full;

  // Traffic controls and counters of the request and result processes.
  bit          no_idle;
  int          sink_hold;
  int          pool_settings;
  logic [31:0] recent_sizes [4];
  int          recent_idx;

  first_fit_free_list_allocator_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  allocator_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .requests_o   (requests),
    .grants_o     (grants),
    .nofit_o      (nofit),
    .full_o       (full)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result sink: stalls a random number of cycles before each beat, or a long
  // stretch when asked to.
  initial begin : result_sink
    int hold;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        hold      = sink_hold;
        sink_hold = 0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Offers one request beat after a random gap; returns at the falling edge
  // after it has been taken.
  task automatic send_request(input logic func, input logic [31:0] nbytes,
                              input logic [31:0] addr);
    in_item_t beat;
    int       gap;
    beat.func         = func;
    beat.req_bytes    = nbytes;
    beat.release_addr = addr;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Lowers valid and waits until every outstanding result has come back.
  task automatic drain_requests();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Register access with a setup and an enable phase; the checker compares read data.
  task automatic reg_access(input logic wr, input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // New pool setting, written and read back while the block is idle.
  task automatic set_pool(input logic [31:0] base, input logic [31:0] nbytes);
    drain_requests();
    reg_access(1'b1, REG_POOL_BASE, base);
    reg_access(1'b1, REG_POOL_BYTES, nbytes);
    reg_access(1'b0, REG_POOL_BASE, '0);
    reg_access(1'b0, REG_POOL_BYTES, '0);
    pool_settings++;
    recent_sizes[0] = nbytes;
    recent_sizes[1] = nbytes >> 1;
    recent_sizes[2] = nbytes >> 2;
    recent_sizes[3] = 32'd1;
  endtask

  // Random request: sizes mostly within a fraction of the pool, some exact
  // repeats of freed sizes so that segments get used up, some zero or huge.
  task automatic random_request(input logic [31:0] span);
    logic [31:0] nbytes;
    logic [31:0] addr;
    int          pick;
    addr = $urandom;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       nbytes = '0;
      1:       nbytes = $urandom;
      2, 3:    nbytes = recent_sizes[$urandom_range(0, 3)];
      default: nbytes = $urandom_range(1, span);
    endcase
    if ($urandom_range(0, 99) < 55) begin
      send_request(FUNC_ALLOC, nbytes, addr);
    end else begin
      send_request(FUNC_FREE, nbytes, addr);
      recent_sizes[recent_idx] = nbytes;
      recent_idx = (recent_idx + 1) % 4;
    end
  endtask

  // One random phase under a given pool setting.
  task automatic run_phase(input logic [31:0] base, input logic [31:0] nbytes,
                           input int count, input bit quiet, input bit pressure);
    logic [31:0] span;
    set_pool(base, nbytes);
    span    = ((nbytes >> 3) > 32'd16) ? (nbytes >> 3) : 32'd16;
    no_idle = quiet;
    for (int n = 0; n < count; n++) begin
      // Long result stall while requests keep coming, later a full pause.
      if (pressure && n == 20) sink_hold = 60;
      if (pressure && n == 60) drain_requests();
      random_request(span);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    out_stall     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    no_idle       = 1'b0;
    sink_hold     = 0;
    pool_settings = 0;
    recent_idx    = 0;
    for (int k = 0; k < 4; k++) recent_sizes[k] = 32'd16;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Straight out of reset the pool is empty.
    send_request(FUNC_ALLOC, 32'h0, 32'h0);
    send_request(FUNC_FREE, 32'h40, 32'h0);
    send_request(FUNC_ALLOC, 32'h40, 32'h0);

    // Directed part on a small pool.
    set_pool(32'h0000_1000, 32'h0000_1000);
    send_request(FUNC_ALLOC, 32'h0, 32'hFFFF_FFFF);
    send_request(FUNC_ALLOC, 32'hFFFF_FFFF, 32'h0);
    send_request(FUNC_ALLOC, 32'h100, 32'h0);
    send_request(FUNC_FREE, 32'h0, 32'hFFFF_FFFF);
    // A segment at the top of the address space: its base wraps when carved.
    send_request(FUNC_FREE, 32'h20, 32'hFFFF_FFF0);
    send_request(FUNC_ALLOC, 32'h10, 32'h0);
    send_request(FUNC_ALLOC, 32'h10, 32'h0);
    // Use up the rest of the pool, then the list is empty.
    send_request(FUNC_ALLOC, 32'hF00, 32'h0);
    send_request(FUNC_ALLOC, 32'h0, 32'h0);
    // The free total wraps past the top.
    send_request(FUNC_FREE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(FUNC_FREE, 32'h1, 32'h5555_5555);
    // Fill the list to its depth, then one free too many.
    for (int k = 0; k < 14; k++) send_request(FUNC_FREE, 32'h10, 32'hA000_0000 + 32'(k << 4));
    send_request(FUNC_FREE, 32'h10, 32'hAAAA_AAAA);
    send_request(FUNC_ALLOC, 32'h10, 32'h0);
    send_request(FUNC_ALLOC, 32'h8, 32'h0);

    // Random phases under assorted pool settings, extremes included.
    run_phase(32'h0000_0000, 32'hFFFF_FFFF, 105, 1'b0, 1'b1);
    run_phase(32'hFFFF_FF00, 32'h0000_0200, 105, 1'b0, 1'b0);
    run_phase($urandom, 32'h0, 100, 1'b0, 1'b0);
    run_phase($urandom, $urandom_range(64, 4096), 105, 1'b1, 1'b0);
    run_phase($urandom, $urandom, 105, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 105, 1'b0, 1'b0);

    drain_requests();
    repeat (40) @(negedge clk);

    $display("Run covered %0d requests under %0d pool settings.", requests, pool_settings);
    $display("Grants %0d, no-fit answers %0d, list-full answers %0d.", grants, nofit, full);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
